// ===== rtl/wavp_pkg.sv =====
// Shared types and constants for the wave header parser.
`default_nettype none
package wavp_pkg;

    localparam int unsigned HEADER_LAST = 43;
    localparam logic [15:0] FORMAT_BASE_RST = 16'd4352;
    localparam logic [7:0] FMT_SIZE_LOW = 8'd16;
    localparam logic [7:0] AUDIO_FMT_PCM = 8'd1;
    localparam logic [15:0] FORMAT_ADJ = 16'd3;

    // tags held little-endian: byte k of the tag sits at bits [8k+7:8k]
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_HDR = 3'd0,
        ST_HDR_DONE = 3'd1,
        ST_PAYLOAD = 3'd2,
        ST_INVALID = 3'd3,
        ST_IGNORED = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic [15:0] channel_count;
        logic [31:0] freq_hz;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
        logic [15:0] format_code;
    } t_out_req;

    // classified byte passed from front to back
    typedef struct packed {
        t_status     status;
        logic [7:0]  payload_byte;
        logic        last_payload;
        logic [15:0] channel_count;
        logic [31:0] freq_hz;
        logic [15:0] sample_bits;
        logic [31:0] data_length;
    } t_item;

    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
        tag_byte = tag[8*idx +: 8];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/wavp_front.sv =====
// Front end: accepts file bytes, tracks the header parse and classifies each byte.
`default_nettype none
module wavp_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire wavp_pkg::t_in_req i_req,
    input  wire logic             i_full,
    output logic                  o_push,
    output wavp_pkg::t_item       o_item
);

    logic [5:0]       r_off, n_off, e_off;
    wavp_pkg::t_phase r_phase, n_phase, e_phase;
    logic [15:0]      r_ch, n_ch, e_ch;
    logic [31:0]      r_rate, n_rate, e_rate;
    logic [15:0]      r_bits, n_bits, e_bits;
    logic [31:0]      r_size, n_size, e_size;
    logic [31:0]      r_left, n_left, e_left;
    logic             ok;
    logic [7:0]       b;
    logic             start;

    assign o_push = i_valid && !i_full;
    assign b = i_req.file_byte;
    assign start = i_req.start_of_file;

    always_comb begin
        e_off = start ? 6'd0 : r_off;
        e_phase = start ? wavp_pkg::PH_HEADER : r_phase;
        e_ch = start ? 16'd0 : r_ch;
        e_rate = start ? 32'd0 : r_rate;
        e_bits = start ? 16'd0 : r_bits;
        e_size = start ? 32'd0 : r_size;
        e_left = start ? 32'd0 : r_left;

        n_off = r_off;
        n_phase = r_phase;
        n_ch = r_ch;
        n_rate = r_rate;
        n_bits = r_bits;
        n_size = r_size;
        n_left = r_left;
        ok = 1'b1;
        o_item = '0;
        o_item.status = wavp_pkg::ST_HDR;

        if (o_push) begin
            n_off = e_off;
            n_phase = e_phase;
            n_ch = e_ch;
            n_rate = e_rate;
            n_bits = e_bits;
            n_size = e_size;
            n_left = e_left;
            case (e_phase)
                wavp_pkg::PH_HEADER: begin
                    case (e_off) inside
                        [6'd0:6'd3]: begin
                            ok = (b == wavp_pkg::tag_byte(wavp_pkg::TAG_RIFF, e_off[1:0]));
                        end
                        [6'd8:6'd11]: begin
                            ok = (b == wavp_pkg::tag_byte(wavp_pkg::TAG_WAVE, e_off[1:0]));
                        end
                        [6'd12:6'd15]: begin
                            ok = (b == wavp_pkg::tag_byte(wavp_pkg::TAG_FMT, e_off[1:0]));
                        end
                        6'd16:         ok = (b == wavp_pkg::FMT_SIZE_LOW);
                        6'd20:         ok = (b == wavp_pkg::AUDIO_FMT_PCM);
                        6'd22, 6'd23:  n_ch[8*e_off[0] +: 8] = e_ch[8*e_off[0] +: 8] | b;
                        [6'd24:6'd27]: n_rate[8*e_off[1:0] +: 8] = e_rate[8*e_off[1:0] +: 8] | b;
                        6'd34, 6'd35:  n_bits[8*e_off[0] +: 8] = e_bits[8*e_off[0] +: 8] | b;
                        [6'd36:6'd39]: begin
                            ok = (b == wavp_pkg::tag_byte(wavp_pkg::TAG_DATA, e_off[1:0]));
                        end
                        [6'd40:6'd43]: n_size[8*e_off[1:0] +: 8] = e_size[8*e_off[1:0] +: 8] | b;
                        default:       ok = 1'b1;
                    endcase
                    if (!ok) begin
                        n_phase = wavp_pkg::PH_ERROR;
                        o_item.status = wavp_pkg::ST_INVALID;
                    end else if (e_off >= 6'(wavp_pkg::HEADER_LAST)) begin
                        o_item.status = wavp_pkg::ST_HDR_DONE;
                        n_left = n_size;
                        n_phase = (n_size != 32'd0) ? wavp_pkg::PH_PAYLOAD : wavp_pkg::PH_DONE;
                    end else begin
                        n_off = e_off + 6'd1;
                        o_item.status = wavp_pkg::ST_HDR;
                    end
                end
                wavp_pkg::PH_PAYLOAD: begin
                    o_item.status = wavp_pkg::ST_PAYLOAD;
                    o_item.payload_byte = b;
                    n_left = e_left - 32'd1;
                    if (n_left == 32'd0) begin
                        o_item.last_payload = 1'b1;
                        n_phase = wavp_pkg::PH_DONE;
                    end
                end
                wavp_pkg::PH_ERROR: o_item.status = wavp_pkg::ST_INVALID;
                default: o_item.status = wavp_pkg::ST_IGNORED;
            endcase
            if (o_item.status != wavp_pkg::ST_HDR
                    && o_item.status != wavp_pkg::ST_INVALID) begin
                o_item.channel_count = n_ch;
                o_item.freq_hz = n_rate;
                o_item.sample_bits = n_bits;
                o_item.data_length = n_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
            r_phase <= wavp_pkg::PH_HEADER;
            r_ch <= '0;
            r_rate <= '0;
            r_bits <= '0;
            r_size <= '0;
            r_left <= '0;
        end else begin
            r_off <= n_off;
            r_phase <= n_phase;
            r_ch <= n_ch;
            r_rate <= n_rate;
            r_bits <= n_bits;
            r_size <= n_size;
            r_left <= n_left;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wavp_queue.sv =====
// Two-entry queue between the front end and the back end.
`default_nettype none
module wavp_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire wavp_pkg::t_item i_item,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output wavp_pkg::t_item      o_item
);

    wavp_pkg::t_item r_mem [2];
    logic            r_wr, n_wr;
    logic            r_rd, n_rd;
    logic [1:0]      r_cnt, n_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item = r_mem[r_rd];

    always_comb begin
        n_wr = i_push ? ~r_wr : r_wr;
        n_rd = i_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wavp_back.sv =====
// Back end: format code, config register and registered result output.
`default_nettype none
module wavp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [15:0]     i_cfg_data,
    input  wire logic            i_empty,
    input  wire wavp_pkg::t_item i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output wavp_pkg::t_out_req   o_res
);

    logic [15:0]         r_base;
    logic                r_valid, n_valid;
    wavp_pkg::t_out_req  r_res, n_res;
    logic [15:0]         code;

    assign o_pop = !i_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_res = r_res;

    always_comb begin
        code = r_base + {i_item.channel_count[14:0], 1'b0}
             + {3'd0, i_item.sample_bits[15:3]} - wavp_pkg::FORMAT_ADJ;
        n_valid = r_valid;
        n_res = r_res;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        if (o_pop) begin
            n_valid = 1'b1;
            n_res.status = i_item.status;
            n_res.payload_byte = i_item.payload_byte;
            n_res.last_payload = i_item.last_payload;
            n_res.channel_count = i_item.channel_count;
            n_res.freq_hz = i_item.freq_hz;
            n_res.sample_bits = i_item.sample_bits;
            n_res.data_length = i_item.data_length;
            if (i_item.status == wavp_pkg::ST_HDR
                    || i_item.status == wavp_pkg::ST_INVALID) begin
                n_res.format_code = 16'd0;
            end else begin
                n_res.format_code = code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_base <= wavp_pkg::FORMAT_BASE_RST;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/wav_header_parser_unit.sv =====
// Top level of the streaming RIFF/WAVE header parser.
//
//  channel  direction  handshake          payload
//  byte in  input      i_valid / o_stall  i_req (t_in_req)
//  result   output     o_valid / i_stall  o_res (t_out_req)
//  config   input      i_cfg_we           i_cfg_data (format base)
//
// One request per cycle while i_stall stays low; each byte gives one result
// (front classify, then the queue, then the output register).
// A two-entry queue parts the front from the back; o_stall rises only when it is full.
// Reset is synchronous and clears the parse to header offset 0 and the base to 4352.
`default_nettype none
module wav_header_parser_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire wavp_pkg::t_in_req  i_req,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output wavp_pkg::t_out_req      o_res,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data
);

    logic            push, pop, full, empty;
    wavp_pkg::t_item f_item, q_item;

    assign o_stall = full;

    wavp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    wavp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (q_item)
    );

    wavp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_empty    (empty),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_res      (o_res)
    );

endmodule
`default_nettype wire

// ===== tb/wav_header_parser_checker.sv =====
// Result checker for the wave header parser: tracks the parse and compares every result.
module wav_header_parser_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  wavp_pkg::t_in_req  i_in_req,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  wavp_pkg::t_out_req i_out_res,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    logic [15:0]        base_code;
    logic [5:0]         hdr_off;
    wavp_pkg::t_phase   phase;
    logic [15:0]        chan_cnt;
    logic [31:0]        rate_hz;
    logic [15:0]        bits_ps;
    logic [31:0]        data_len;
    logic [31:0]        left_cnt;
    wavp_pkg::t_out_req expected_q[$];
    wavp_pkg::t_out_req want;
    int                 fail_cnt;

    function automatic void clear_parse();
        hdr_off = '0;
        phase = wavp_pkg::PH_HEADER;
        chan_cnt = '0;
        rate_hz = '0;
        bits_ps = '0;
        data_len = '0;
        left_cnt = '0;
    endfunction

    function automatic wavp_pkg::t_out_req parse_byte(input logic [7:0] b, input logic sof);
        wavp_pkg::t_out_req r;
        int o;
        logic ok;
        r = '0;
        if (sof) begin
            clear_parse();
        end
        case (phase)
            wavp_pkg::PH_HEADER: begin
                o = int'(hdr_off);
                ok = 1'b1;
                if (o <= 3) begin
                    ok = (b == wavp_pkg::TAG_RIFF[8*o +: 8]);
                end else if (o >= 8 && o <= 11) begin
                    ok = (b == wavp_pkg::TAG_WAVE[8*(o-8) +: 8]);
                end else if (o >= 12 && o <= 15) begin
                    ok = (b == wavp_pkg::TAG_FMT[8*(o-12) +: 8]);
                end else if (o == 16) begin
                    ok = (b == wavp_pkg::FMT_SIZE_LOW);
                end else if (o == 20) begin
                    ok = (b == wavp_pkg::AUDIO_FMT_PCM);
                end else if (o == 22 || o == 23) begin
                    chan_cnt[8*(o-22) +: 8] = b;
                end else if (o >= 24 && o <= 27) begin
                    rate_hz[8*(o-24) +: 8] = b;
                end else if (o == 34 || o == 35) begin
                    bits_ps[8*(o-34) +: 8] = b;
                end else if (o >= 36 && o <= 39) begin
                    ok = (b == wavp_pkg::TAG_DATA[8*(o-36) +: 8]);
                end else if (o >= 40 && o <= 43) begin
                    data_len[8*(o-40) +: 8] = b;
                end
                if (!ok) begin
                    phase = wavp_pkg::PH_ERROR;
                    r.status = wavp_pkg::ST_INVALID;
                end else if (o >= wavp_pkg::HEADER_LAST) begin
                    r.status = wavp_pkg::ST_HDR_DONE;
                    left_cnt = data_len;
                    phase = (data_len != 0) ? wavp_pkg::PH_PAYLOAD : wavp_pkg::PH_DONE;
                end else begin
                    hdr_off = hdr_off + 6'd1;
                    r.status = wavp_pkg::ST_HDR;
                end
            end
            wavp_pkg::PH_PAYLOAD: begin
                r.status = wavp_pkg::ST_PAYLOAD;
                r.payload_byte = b;
                left_cnt = left_cnt - 32'd1;
                if (left_cnt == 0) begin
                    r.last_payload = 1'b1;
                    phase = wavp_pkg::PH_DONE;
                end
            end
            wavp_pkg::PH_ERROR: begin
                r.status = wavp_pkg::ST_INVALID;
            end
            default: begin
                r.status = wavp_pkg::ST_IGNORED;
            end
        endcase
        if (r.status != wavp_pkg::ST_HDR && r.status != wavp_pkg::ST_INVALID) begin
            r.channel_count = chan_cnt;
            r.freq_hz = rate_hz;
            r.sample_bits = bits_ps;
            r.data_length = data_len;
            r.format_code = base_code + {chan_cnt[14:0], 1'b0} + {3'b000, bits_ps[15:3]}
                            - wavp_pkg::FORMAT_ADJ;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, got_val);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base_code = wavp_pkg::FORMAT_BASE_RST;
            clear_parse();
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                base_code = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_q.insert(expected_q.size(),
                                  parse_byte(i_in_req.file_byte, i_in_req.start_of_file));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_cnt++;
                end else begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    check_field("status", want.status, i_out_res.status);
                    check_field("payload_byte", want.payload_byte, i_out_res.payload_byte);
                    check_field("last_payload", want.last_payload, i_out_res.last_payload);
                    check_field("channel_count", want.channel_count,
                                i_out_res.channel_count);
                    check_field("freq_hz", want.freq_hz, i_out_res.freq_hz);
                    check_field("sample_bits", want.sample_bits, i_out_res.sample_bits);
                    check_field("data_length", want.data_length, i_out_res.data_length);
                    check_field("format_code", want.format_code, i_out_res.format_code);
                end
            end
        end
        o_pending <= expected_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ===== tb/wav_header_parser_unit_test.sv =====
// Top of the wave header parser testbench: stimulus, idling, configuration and verdict.
module wav_header_parser_unit_test;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_stall;
    wavp_pkg::t_in_req  byte_req = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    wavp_pkg::t_out_req res;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_data = '0;
    int                 fail_count;
    int                 pending;
    int                 send_idle = 17;
    int                 recv_idle = 56;
    int                 sent = 0;
    int                 bad_list[18] = '{0, 1, 2, 3, 8, 9, 10, 11, 12, 13, 14, 15, 16, 20,
                                         36, 37, 38, 39};

    wav_header_parser_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (byte_valid),
        .o_stall    (byte_stall),
        .i_req      (byte_req),
        .o_valid    (res_valid),
        .i_stall    (res_stall),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    wav_header_parser_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (byte_valid),
        .i_in_stall   (byte_stall),
        .i_in_req     (byte_req),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_out_res    (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        res_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic push_byte(input logic [7:0] b, input logic sof);
        while ($urandom_range(99) < send_idle) begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_req <= '{file_byte: b, start_of_file: sof};
        @(posedge clk);
        while (byte_stall) begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic wait_idle();
        byte_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_base(input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_file(input logic [15:0] ch, input logic [31:0] rate,
                             input logic [15:0] bits, input logic [31:0] size,
                             input int bad_off, input int hdr_len, input int n_after);
        logic [7:0] hdr [0:43];
        int k;
        for (k = 0; k < 44; k++) begin
            hdr[k] = 8'($urandom_range(255));
        end
        for (k = 0; k < 4; k++) begin
            hdr[k] = wavp_pkg::TAG_RIFF[8*k +: 8];
            hdr[8+k] = wavp_pkg::TAG_WAVE[8*k +: 8];
            hdr[12+k] = wavp_pkg::TAG_FMT[8*k +: 8];
            hdr[24+k] = rate[8*k +: 8];
            hdr[36+k] = wavp_pkg::TAG_DATA[8*k +: 8];
            hdr[40+k] = size[8*k +: 8];
        end
        hdr[16] = wavp_pkg::FMT_SIZE_LOW;
        hdr[20] = wavp_pkg::AUDIO_FMT_PCM;
        hdr[22] = ch[7:0];
        hdr[23] = ch[15:8];
        hdr[34] = bits[7:0];
        hdr[35] = bits[15:8];
        if (bad_off >= 0) begin
            hdr[bad_off] = hdr[bad_off] ^ 8'($urandom_range(255, 1));
        end
        for (k = 0; k < hdr_len; k++) begin
            push_byte(hdr[k], k == 0);
        end
        for (k = 0; k < n_after; k++) begin
            push_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic random_file();
        int kind;
        int bad;
        int hlen;
        int extra;
        logic [15:0] ch;
        logic [15:0] bits;
        logic [31:0] rate;
        logic [31:0] size;
        kind = $urandom_range(99);
        if (kind < 15) begin
            // noise, with stray starts
            repeat ($urandom_range(8, 1)) begin
                push_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            end
            return;
        end
        case ($urandom_range(9))
            0: ch = '0;
            1: ch = 16'hFFFF;
            2: ch = 16'($urandom());
            default: ch = 16'($urandom_range(8, 1));
        endcase
        case ($urandom_range(9))
            0: bits = '0;
            1: bits = 16'hFFFF;
            2: bits = 16'($urandom());
            default: bits = 16'(8 * $urandom_range(4, 1));
        endcase
        case ($urandom_range(9))
            0: rate = '0;
            1: rate = 32'hFFFF_FFFF;
            default: rate = $urandom();
        endcase
        case ($urandom_range(9))
            0, 1: size = '0;
            2: size = $urandom();
            3: size = 32'hFFFF_FFFF;
            default: size = $urandom_range(20, 1);
        endcase
        bad = -1;
        hlen = 44;
        if (kind < 30) begin
            bad = bad_list[$urandom_range(17)];
        end else if (kind < 38) begin
            hlen = $urandom_range(43, 1);
        end
        if (bad >= 0 || hlen < 44) begin
            extra = $urandom_range(4);
        end else if (size <= 20) begin
            extra = int'(size) + $urandom_range(3);
        end else begin
            extra = $urandom_range(12);
        end
        send_file(ch, rate, bits, size, bad, hlen, extra);
    endtask

    initial begin
        int seg;
        logic [15:0] base;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // no start after reset, tag mismatch, sticky error, restarts
        push_byte(wavp_pkg::TAG_RIFF[7:0], 1'b0);
        push_byte(wavp_pkg::TAG_RIFF[15:8], 1'b0);
        push_byte(wavp_pkg::TAG_RIFF[23:16], 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(wavp_pkg::TAG_RIFF[7:0], 1'b1);
        push_byte(wavp_pkg::TAG_RIFF[15:8], 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);

        for (seg = 0; seg < 6; seg++) begin
            send_idle = (seg < 2) ? 17 : (seg < 4) ? 56 : 0;
            recv_idle = (seg < 2) ? 56 : (seg < 4) ? 17 : 0;
            wait_idle();
            case (seg)
                0: base = '0;
                1: base = 16'hFFFF;
                3: base = wavp_pkg::FORMAT_BASE_RST;
                default: base = 16'($urandom());
            endcase
            write_base(base);
            while (sent < 10 + (seg + 1) * 182) begin
                random_file();
            end
        end
        wait_idle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
